// ===== hw/rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
package i2cms_pkg;

  // Default depth of the write buffer.
  localparam int unsigned BUFFER_SIZE_DEF = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_REGISTER = 4'd1,
    PH_ADDRESS  = 4'd2,
    PH_WRITE    = 4'd3,
    PH_READ     = 4'd4,
    PH_SENT     = 4'd5,
    PH_RECEIVED = 4'd6,
    PH_ERROR    = 4'd7,
    PH_OVERFLOW = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ADDR      = 3'd1,
    CMD_DATA      = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_NACK_STOP = 3'd4,
    CMD_ACK_NEXT  = 3'd5
  } cmd_t;

  // Bit positions inside bus_status.
  localparam int unsigned ST_ARB_LOST = 0;
  localparam int unsigned ST_WRITE    = 1;
  localparam int unsigned ST_READ     = 2;
  localparam int unsigned ST_NACK     = 3;

endpackage

// ===== hw/rtl/i2cms_if.sv =====
`timescale 1ns / 1ps
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [4:0] buf_index;
  logic [7:0] buf_byte;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic       use_register;
  logic       is_read;
  logic [7:0] byte_count;
  logic [3:0] bus_status;
  logic [7:0] bus_data;

  modport source (
    output valid, op, buf_index, buf_byte, dev_addr, reg_addr, use_register,
           is_read, byte_count, bus_status, bus_data,
    input  ready
  );
  modport sink (
    input  valid, op, buf_index, buf_byte, dev_addr, reg_addr, use_register,
           is_read, byte_count, bus_status, bus_data,
    output ready
  );
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd_kind;
  logic [7:0] cmd_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic [4:0] rx_position;
  logic [3:0] xfer_status;

  modport source (
    output valid, cmd_kind, cmd_byte, rx_valid, rx_byte, rx_position, xfer_status,
    input  ready
  );
  modport sink (
    input  valid, cmd_kind, cmd_byte, rx_valid, rx_byte, rx_position, xfer_status,
    output ready
  );
endinterface

// ===== hw/rtl/i2cms_buf.sv =====
`timescale 1ns / 1ps
module i2cms_buf
  import i2cms_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_SIZE_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/i2c_master_transaction_sequencer.sv =====
`timescale 1ns / 1ps
// I2C master transaction sequencer.
// Requests arrive on in_req: a load puts a byte into the write buffer, a start
// begins a plain or register write or read, and a bus event (flags plus the
// received byte) asks for the next controller command. Every request yields
// exactly one response on out_rsp: the command, an optional received byte with
// its index, and the transfer phase after the request.
// A request accepted at one edge shows its response after that edge. One
// request is taken every cycle unless a response is held; the write buffer is a
// single-port-read memory read in the accept cycle, and its registered read
// data forms part of the output stage, so no request waits on another.
// When the receiver stalls, the response stays registered and in_req.ready
// drops until it is taken; a response leaving frees the stage in the same cycle.
// Reset puts the phase to idle and clears lengths, positions and addresses.
// The buffer is not cleared; sending a byte that was never loaded is not
// meaningful and returns whatever the memory holds.
module i2c_master_transaction_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cms_in_if.sink     in_req,
  i2cms_out_if.source  out_rsp
);

  localparam int unsigned AW = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
  localparam logic [7:0] BUF_SIZE8 = 8'(BUFFER_SIZE);

  // Transfer state kept in flip-flops.
  phase_t     phase_r, phase_nxt;
  logic [6:0] target_r, target_nxt;
  logic [7:0] regbyte_r, regbyte_nxt;
  logic [7:0] wlen_r, wlen_nxt;
  logic [7:0] rlen_r, rlen_nxt;
  logic [7:0] wpos_r, wpos_nxt;
  logic [7:0] rpos_r, rpos_nxt;

  // Output stage. When use_mem_r is set, the command byte comes from the
  // buffer read data, which is registered inside the memory.
  logic       out_valid_r, out_valid_nxt;
  cmd_t       kind_r, kind_nxt;
  logic [7:0] cbyte_r, cbyte_nxt;
  logic       use_mem_r, use_mem_nxt;
  logic       rxv_r, rxv_nxt;
  logic [7:0] rxb_r, rxb_nxt;
  logic [4:0] rxp_r, rxp_nxt;
  phase_t     status_r;

  logic       in_fire;
  logic       mem_we, mem_re;
  logic [7:0] load_idx;
  logic [7:0] mem_rdata;
  logic [7:0] rpos_inc;
  logic [3:0] st;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign in_fire      = in_req.valid && in_req.ready;
  assign load_idx     = {3'b000, in_req.buf_index};
  assign rpos_inc     = rpos_r + 8'd1;
  assign st           = in_req.bus_status;

  i2cms_buf #(
    .DEPTH (BUFFER_SIZE),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_idx[AW-1:0]),
    .wdata (in_req.buf_byte),
    .re    (mem_re),
    .raddr (wpos_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      target_r    <= '0;
      regbyte_r   <= '0;
      wlen_r      <= '0;
      rlen_r      <= '0;
      wpos_r      <= '0;
      rpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      target_r    <= target_nxt;
      regbyte_r   <= regbyte_nxt;
      wlen_r      <= wlen_nxt;
      rlen_r      <= rlen_nxt;
      wpos_r      <= wpos_nxt;
      rpos_r      <= rpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= kind_nxt;
      cbyte_r   <= cbyte_nxt;
      use_mem_r <= use_mem_nxt;
      rxv_r     <= rxv_nxt;
      rxb_r     <= rxb_nxt;
      rxp_r     <= rxp_nxt;
      status_r  <= phase_nxt;
    end
  end

  // Next state and response for the accepted request.
  always_comb begin
    phase_nxt     = phase_r;
    target_nxt    = target_r;
    regbyte_nxt   = regbyte_r;
    wlen_nxt      = wlen_r;
    rlen_nxt      = rlen_r;
    wpos_nxt      = wpos_r;
    rpos_nxt      = rpos_r;
    kind_nxt      = CMD_NONE;
    cbyte_nxt     = 8'd0;
    use_mem_nxt   = 1'b0;
    rxv_nxt       = 1'b0;
    rxb_nxt       = 8'd0;
    rxp_nxt       = 5'd0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_valid_nxt = out_valid_r && !out_rsp.ready;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      case (op_t'(in_req.op))
        OP_LOAD: begin
          mem_we = load_idx < BUF_SIZE8;
        end
        OP_START: begin
          target_nxt  = in_req.dev_addr;
          wpos_nxt    = 8'd0;
          rpos_nxt    = 8'd0;
          regbyte_nxt = in_req.use_register ? in_req.reg_addr : 8'd0;
          if (in_req.is_read) begin
            wlen_nxt = 8'd0;
            rlen_nxt = in_req.byte_count;
          end else begin
            rlen_nxt = 8'd0;
            wlen_nxt = (in_req.byte_count > BUF_SIZE8) ? BUF_SIZE8 : in_req.byte_count;
          end
          kind_nxt = CMD_ADDR;
          if (in_req.use_register) begin
            phase_nxt = PH_REGISTER;
            cbyte_nxt = {in_req.dev_addr, 1'b0};
          end else if (in_req.is_read) begin
            phase_nxt = PH_READ;
            cbyte_nxt = {in_req.dev_addr, 1'b1};
          end else begin
            phase_nxt = PH_WRITE;
            cbyte_nxt = {in_req.dev_addr, 1'b0};
          end
        end
        OP_EVENT: begin
          if (st[ST_ARB_LOST]) begin
            phase_nxt = PH_ERROR;
            kind_nxt  = CMD_STOP;
          end else if (st[ST_WRITE]) begin
            if (st[ST_NACK]) begin
              phase_nxt = PH_ERROR;
              kind_nxt  = CMD_STOP;
            end else if (phase_r == PH_REGISTER) begin
              phase_nxt = (rlen_r != 8'd0) ? PH_ADDRESS : PH_WRITE;
              kind_nxt  = CMD_DATA;
              cbyte_nxt = regbyte_r;
            end else if (phase_r == PH_ADDRESS) begin
              phase_nxt = PH_READ;
              kind_nxt  = CMD_ADDR;
              cbyte_nxt = {target_r, 1'b1};
            end else if (phase_r == PH_WRITE) begin
              // The write length is already clamped to the buffer depth.
              if (wpos_r < wlen_r) begin
                mem_re      = 1'b1;
                use_mem_nxt = 1'b1;
                wpos_nxt    = wpos_r + 8'd1;
                kind_nxt    = CMD_DATA;
              end else begin
                phase_nxt = PH_SENT;
                kind_nxt  = CMD_STOP;
              end
            end
          end else if (st[ST_READ]) begin
            if (phase_r != PH_READ) begin
              phase_nxt = PH_ERROR;
              kind_nxt  = CMD_STOP;
            end else if (rpos_r >= BUF_SIZE8) begin
              phase_nxt = PH_OVERFLOW;
              kind_nxt  = CMD_NACK_STOP;
            end else begin
              rpos_nxt = rpos_inc;
              rxv_nxt  = 1'b1;
              rxb_nxt  = in_req.bus_data;
              rxp_nxt  = rpos_r[4:0];
              if (rpos_inc < rlen_r) begin
                kind_nxt = CMD_ACK_NEXT;
              end else begin
                phase_nxt = PH_RECEIVED;
                kind_nxt  = CMD_NACK_STOP;
              end
            end
          end else begin
            phase_nxt = PH_ERROR;
            kind_nxt  = CMD_STOP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.cmd_kind    = kind_r;
  assign out_rsp.cmd_byte    = use_mem_r ? mem_rdata : cbyte_r;
  assign out_rsp.rx_valid    = rxv_r;
  assign out_rsp.rx_byte     = rxb_r;
  assign out_rsp.rx_position = rxp_r;
  assign out_rsp.xfer_status = status_r;

endmodule

// ===== tb/i2cms_tb_pkg.sv =====
`timescale 1ns / 1ps
package i2cms_tb_pkg;
  import i2cms_pkg::*;

  localparam int unsigned BUF_DEPTH = BUFFER_SIZE_DEF;

  typedef struct {
    op_t        op;
    logic [4:0] buf_index;
    logic [7:0] buf_byte;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       use_register;
    logic       is_read;
    logic [7:0] byte_count;
    logic [3:0] bus_status;
    logic [7:0] bus_data;
  } req_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] cmd_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_pos;
    logic [3:0] status;
  } rsp_t;

  class command_scoreboard;
    phase_t     phase       = PH_IDLE;
    logic [6:0] target_addr = '0;
    logic [7:0] reg_byte    = '0;
    logic [7:0] wr_len      = '0;
    logic [7:0] rd_len      = '0;
    logic [7:0] wr_pos      = '0;
    logic [7:0] rd_pos      = '0;
    logic [7:0] wr_buf [BUF_DEPTH];
    rsp_t       pending_cmds [$];

    int unsigned errors     = 0;
    int unsigned checked    = 0;
    int unsigned rx_bytes   = 0;
    int unsigned n_sent     = 0;
    int unsigned n_received = 0;
    int unsigned n_overflow = 0;
    int unsigned n_error    = 0;

    function int pending();
      return pending_cmds.size();
    endfunction

    function void enter_error(ref rsp_t e);
      phase  = PH_ERROR;
      e.kind = CMD_STOP;
      n_error++;
    endfunction

    // Advances the sequencer state by one accepted request and queues the
    // command that it must produce.
    function void note_request(req_t r);
      rsp_t e;
      e = '{kind: CMD_NONE, cmd_byte: 8'h00, rx_valid: 1'b0, rx_byte: 8'h00,
            rx_pos: 5'd0, status: 4'd0};
      case (r.op)
        OP_LOAD: begin
          if (r.buf_index < BUF_DEPTH) wr_buf[r.buf_index] = r.buf_byte;
        end
        OP_START: begin
          target_addr = r.dev_addr;
          wr_pos      = '0;
          rd_pos      = '0;
          reg_byte    = r.use_register ? r.reg_addr : 8'h00;
          if (r.is_read) begin
            wr_len = '0;
            rd_len = r.byte_count;
          end else begin
            rd_len = '0;
            wr_len = (r.byte_count > BUF_DEPTH) ? 8'(BUF_DEPTH) : r.byte_count;
          end
          e.kind     = CMD_ADDR;
          e.cmd_byte = {r.dev_addr, ~r.use_register & r.is_read};
          if (r.use_register) phase = PH_REGISTER;
          else if (r.is_read) phase = PH_READ;
          else phase = PH_WRITE;
        end
        OP_EVENT: begin
          if (r.bus_status[ST_ARB_LOST]) begin
            enter_error(e);
          end else if (r.bus_status[ST_WRITE]) begin
            if (r.bus_status[ST_NACK]) begin
              enter_error(e);
            end else begin
              case (phase)
                PH_REGISTER: begin
                  e.kind     = CMD_DATA;
                  e.cmd_byte = reg_byte;
                  phase      = (rd_len != 0) ? PH_ADDRESS : PH_WRITE;
                end
                PH_ADDRESS: begin
                  e.kind     = CMD_ADDR;
                  e.cmd_byte = {target_addr, 1'b1};
                  phase      = PH_READ;
                end
                PH_WRITE: begin
                  if (wr_pos < wr_len && wr_pos < BUF_DEPTH) begin
                    e.kind     = CMD_DATA;
                    e.cmd_byte = wr_buf[wr_pos];
                    wr_pos++;
                  end else begin
                    e.kind = CMD_STOP;
                    phase  = PH_SENT;
                    n_sent++;
                  end
                end
                default: ;
              endcase
            end
          end else if (r.bus_status[ST_READ]) begin
            if (phase != PH_READ) begin
              enter_error(e);
            end else if (rd_pos >= BUF_DEPTH) begin
              e.kind = CMD_NACK_STOP;
              phase  = PH_OVERFLOW;
              n_overflow++;
            end else begin
              e.rx_valid = 1'b1;
              e.rx_byte  = r.bus_data;
              e.rx_pos   = rd_pos[4:0];
              rx_bytes++;
              rd_pos++;
              if (rd_pos < rd_len) begin
                e.kind = CMD_ACK_NEXT;
              end else begin
                e.kind = CMD_NACK_STOP;
                phase  = PH_RECEIVED;
                n_received++;
              end
            end
          end else begin
            enter_error(e);
          end
        end
        default: ;
      endcase
      e.status = phase;
      pending_cmds.push_back(e);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      checked++;
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding, kind %0h status %0h",
                 $time, got.kind, got.status);
        return;
      end
      e = pending_cmds.pop_front();
      compare_field("cmd_kind", e.kind, got.kind);
      compare_field("cmd_byte", e.cmd_byte, got.cmd_byte);
      compare_field("rx_valid", e.rx_valid, got.rx_valid);
      compare_field("rx_byte", e.rx_byte, got.rx_byte);
      compare_field("rx_position", e.rx_pos, got.rx_pos);
      compare_field("xfer_status", e.status, got.status);
    endfunction
  endclass

endpackage

// ===== tb/tb_i2c_master_transaction_sequencer.sv =====
`timescale 1ns / 1ps
module tb_i2c_master_transaction_sequencer;
  import i2cms_pkg::*;
  import i2cms_tb_pkg::*;

  // This limit leaves a wide margin for a run of about 1300 requests.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned TARGET_ITEMS = 1300;
  localparam int unsigned DRAIN_EVERY  = 250;

  logic clk;
  logic rst_n;

  i2cms_in_if  in_req ();
  i2cms_out_if out_rsp ();

  i2c_master_transaction_sequencer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  command_scoreboard sb;

  // Which write buffer entries have been loaded so far. A write transfer never
  // asks for more bytes than the run of loaded entries from index zero, so the
  // block never sends a byte that was never stored.
  logic [BUF_DEPTH-1:0] loaded;
  int unsigned n_items;
  int unsigned cycle_count;
  bit          sender_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response monitor. Outputs are sampled at the rising edge, so the values
  // seen are the ones the block held just before the edge.
  always @(posedge clk) begin : response_monitor
    rsp_t got;
    if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      got.kind     = out_rsp.cmd_kind;
      got.cmd_byte = out_rsp.cmd_byte;
      got.rx_valid = out_rsp.rx_valid;
      got.rx_byte  = out_rsp.rx_byte;
      got.rx_pos   = out_rsp.rx_position;
      got.status   = out_rsp.xfer_status;
      sb.check_response(got);
    end
  end

  // Response back-pressure. Ready changes only at the falling edge and is held
  // for a run of cycles: mostly short stalls, a few long ones, and now and then
  // a long stretch with ready held high.
  initial begin : response_stall
    int run;
    int pick;
    run = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          out_rsp.ready = 1'b1;
          run = $urandom_range(50, 200);
        end else if (pick < 55) begin
          out_rsp.ready = 1'b1;
          run = $urandom_range(1, 8);
        end else if (pick < 90) begin
          out_rsp.ready = 1'b0;
          run = $urandom_range(1, 3);
        end else if (pick < 98) begin
          out_rsp.ready = 1'b0;
          run = $urandom_range(4, 12);
        end else begin
          out_rsp.ready = 1'b0;
          run = $urandom_range(20, 40);
        end
      end
      run--;
    end
  end

  // Idle cycles before the next request: mostly none or short, rarely long.
  // In quiet stretches the sender drives back to back.
  function automatic int pick_gap();
    int pick;
    if ($urandom_range(0, 149) == 0) sender_quiet = ~sender_quiet;
    if (sender_quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int loaded_prefix();
    for (int i = 0; i < BUF_DEPTH; i++)
      if (!loaded[i]) return i;
    return BUF_DEPTH;
  endfunction

  // Byte counts favor short transfers, with a share around the buffer size so
  // that reads overflow and writes get clamped. Write counts stay within the
  // loaded part of the buffer until every entry has been written once.
  function automatic logic [7:0] pick_count(logic rd);
    int pick;
    int cnt;
    int safe;
    pick = $urandom_range(0, 99);
    if (pick < 70) cnt = $urandom_range(0, 6);
    else if (pick < 85) cnt = $urandom_range(28, 40);
    else cnt = $urandom_range(0, 255);
    safe = loaded_prefix();
    if (!rd && safe < BUF_DEPTH && cnt > safe) cnt = $urandom_range(0, safe);
    return 8'(cnt);
  endfunction

  // Every field gets random content; callers then set what the request needs.
  function automatic req_t random_request();
    req_t r;
    r.op           = op_t'($urandom_range(0, 3));
    r.buf_index    = 5'($urandom);
    r.buf_byte     = 8'($urandom);
    r.dev_addr     = 7'($urandom);
    r.reg_addr     = 8'($urandom);
    r.use_register = 1'($urandom);
    r.is_read      = 1'($urandom);
    r.bus_status   = 4'($urandom);
    r.bus_data     = 8'($urandom);
    r.byte_count   = pick_count(r.is_read);
    return r;
  endfunction

  // Presents one request and holds it until the block takes it. Called at a
  // falling edge and returns at a falling edge, so valid stays high across
  // back-to-back requests with a single assignment per edge.
  task automatic send_request(input req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.op           = r.op;
    in_req.buf_index    = r.buf_index;
    in_req.buf_byte     = r.buf_byte;
    in_req.dev_addr     = r.dev_addr;
    in_req.reg_addr     = r.reg_addr;
    in_req.use_register = r.use_register;
    in_req.is_read      = r.is_read;
    in_req.byte_count   = r.byte_count;
    in_req.bus_status   = r.bus_status;
    in_req.bus_data     = r.bus_data;
    in_req.valid        = 1'b1;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    sb.note_request(r);
    if (r.op == OP_LOAD) loaded[r.buf_index] = 1'b1;
    if (r.op != OP_NONE) n_items++;
    @(negedge clk);
  endtask

  // Holds off the sender until every queued command has come back.
  task automatic drain_responses();
    in_req.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [4:0] idx, input logic [7:0] data);
    req_t r;
    r = random_request();
    r.op        = OP_LOAD;
    r.buf_index = idx;
    r.buf_byte  = data;
    send_request(r);
  endtask

  task automatic start_xfer(input logic [6:0] dev, input logic [7:0] regb,
                            input logic use_reg, input logic rd, input logic [7:0] cnt);
    req_t r;
    r = random_request();
    r.op           = OP_START;
    r.dev_addr     = dev;
    r.reg_addr     = regb;
    r.use_register = use_reg;
    r.is_read      = rd;
    r.byte_count   = cnt;
    send_request(r);
  endtask

  task automatic bus_event(input logic [3:0] st, input logic [7:0] data);
    req_t r;
    r = random_request();
    r.op         = OP_EVENT;
    r.bus_status = st;
    r.bus_data   = data;
    send_request(r);
  endtask

  // One transfer from start to its stop, driven by well-formed bus events.
  // The flag bits that the current phase ignores still carry random values.
  // Now and then a stray event, an arbitration loss, a NACK or a load lands in
  // the middle, or the transfer is dropped and the next start replaces it.
  task automatic run_transfer();
    req_t r;
    int steps;
    int pick;
    r = random_request();
    r.op = OP_START;
    send_request(r);
    steps = 0;
    while ((sb.phase inside {PH_REGISTER, PH_ADDRESS, PH_WRITE, PH_READ}) && steps < 80) begin
      steps++;
      pick = $urandom_range(0, 99);
      r = random_request();
      if (pick < 2) break;
      if (pick < 5) begin
        r.op = OP_EVENT;
      end else if (pick < 7) begin
        r.op = OP_LOAD;
      end else begin
        r.op = OP_EVENT;
        if (sb.phase == PH_READ) r.bus_status = {r.bus_status[3], 3'b100};
        else r.bus_status = {1'b0, r.bus_status[2], 2'b10};
      end
      send_request(r);
    end
    // A late event after the stop: a write event with no NACK or arbitration loss is ignored, others fail.
    if ($urandom_range(0, 9) == 0) begin
      r = random_request();
      r.op = OP_EVENT;
      send_request(r);
    end
  endtask

  initial begin : stimulus
    req_t r;
    int pick;
    int next_drain;
    int idx;

    sb = new();
    loaded       = '0;
    n_items      = 0;
    cycle_count  = 0;
    sender_quiet = 1'b0;

    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.op           = OP_LOAD;
    in_req.buf_index    = '0;
    in_req.buf_byte     = '0;
    in_req.dev_addr     = '0;
    in_req.reg_addr     = '0;
    in_req.use_register = 1'b0;
    in_req.is_read      = 1'b0;
    in_req.byte_count   = '0;
    in_req.bus_status   = '0;
    in_req.bus_data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Buffer extremes first, so the short writes below only
    // touch loaded entries.
    load_byte(5'd0, 8'h00);
    load_byte(5'd31, 8'hFF);
    load_byte(5'd1, 8'hA5);
    load_byte(5'd2, 8'h5A);
    r = random_request();
    r.op = OP_NONE;
    send_request(r);
    // An event with no flag set stops with an error; a write event in the
    // error phase then produces no command at all.
    bus_event(4'b0000, 8'h00);
    bus_event(4'b0010, 8'hFF);
    // Plain write of three bytes to the highest address, then the stop.
    start_xfer(7'h7F, 8'h00, 1'b0, 1'b0, 8'd3);
    repeat (4) bus_event(4'b0010, 8'h00);
    // Register write with no data bytes.
    start_xfer(7'h00, 8'hFF, 1'b1, 1'b0, 8'd0);
    repeat (2) bus_event(4'b0010, 8'h00);
    // Register read of one byte: register byte, repeated start, one read.
    start_xfer(7'h55, 8'h00, 1'b1, 1'b1, 8'd1);
    repeat (2) bus_event(4'b0010, 8'h00);
    bus_event(4'b0100, 8'hFF);
    // A read that is replaced mid-way by a write, which the target NACKs.
    start_xfer(7'h2A, 8'h81, 1'b0, 1'b1, 8'd2);
    bus_event(4'b0100, 8'h00);
    start_xfer(7'h01, 8'h00, 1'b0, 1'b0, 8'd1);
    bus_event(4'b1010, 8'h00);
    // A read of zero bytes still takes one byte and ends with NACK and stop.
    start_xfer(7'h40, 8'h00, 1'b0, 1'b1, 8'd0);
    bus_event(4'b0100, 8'h3C);
    // Arbitration lost with every flag set, then a read event out of place.
    start_xfer(7'h12, 8'h34, 1'b1, 1'b1, 8'd5);
    bus_event(4'b1111, 8'hFF);
    bus_event(4'b0100, 8'hFF);

    // The sender waits for the block to go quiet at least once here.
    drain_responses();
    next_drain = n_items + DRAIN_EVERY;

    // Random part. Overflowing reads and clamped writes come from transfers
    // whose byte count reaches past the buffer size.
    while (n_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 3)) begin
          idx = loaded_prefix();
          if (idx >= BUF_DEPTH || $urandom_range(0, 1) == 0) idx = $urandom_range(0, BUF_DEPTH - 1);
          load_byte(5'(idx), 8'($urandom));
        end
      end else if (pick < 85) begin
        run_transfer();
      end else if (pick < 97) begin
        send_request(random_request());
      end else begin
        drain_responses();
      end
      if (n_items >= next_drain) begin
        drain_responses();
        next_drain = n_items + DRAIN_EVERY;
      end
    end

    // Wait for every command to come back, then keep the clock running so that a
    // stray extra response would still be seen.
    in_req.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests, checked %0d responses: %0d writes stopped, %0d reads done,",
             n_items, sb.checked, sb.n_sent, sb.n_received);
    $display("%0d read overflows, %0d error stops, %0d bytes received, %0d mismatches.",
             sb.n_overflow, sb.n_error, sb.rx_bytes, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_if.sv
hw/rtl/i2cms_buf.sv
hw/rtl/i2c_master_transaction_sequencer.sv
tb/i2cms_tb_pkg.sv
tb/tb_i2c_master_transaction_sequencer.sv
